// ===== rtl/snap_candidate_selector_macros.svh =====
// ----------------------------------------------------------------------------
// Snap candidate selector assertion macros
// Shared assertion forms for the checker of the snap candidate selector.
// ----------------------------------------------------------------------------
`ifndef SNAP_CANDIDATE_SELECTOR_MACROS_SVH
`define SNAP_CANDIDATE_SELECTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SNC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snap candidate selector check failed");

// Consequent must hold in the cycle after the antecedent.
`define SNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snap candidate selector check failed");

`endif

// ===== rtl/snc_pkg.sv =====
// ----------------------------------------------------------------------------
// Snap candidate selector package
// Item types, register addresses and fixed widths shared across the block.
// ----------------------------------------------------------------------------
package snc_pkg;

    localparam int KIND_W   = 3;
    localparam int OBJ_W    = 32;
    localparam int DIST_W   = 16;
    localparam int WORD_W   = 32;
    localparam int MASK_W   = 6;

    localparam logic [KIND_W-1:0] KIND_NONE = 3'd6;

    // Exponent field of an IEEE single word.
    localparam int             EXP_LSB     = 23;
    localparam int             EXP_W       = 8;
    localparam logic [EXP_W-1:0] EXP_SPECIAL = 8'hFF;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam logic [QPTR_W:0] QCOUNT_FULL = 2'd2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_ALLOWED_KINDS = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_DISTANCE  = 3'd4;

    localparam logic [MASK_W-1:0] ALLOWED_KINDS_RESET = 6'h3F;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET  = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] snap_kind;
        logic [OBJ_W-1:0]  object_id;
        logic [DIST_W-1:0] screen_distance;
        logic              distance_is_finite;
        logic [WORD_W-1:0] position_x;
        logic [WORD_W-1:0] position_y;
        logic [WORD_W-1:0] position_z;
        logic              last_in_list;
    } cand_t;

    typedef struct packed {
        logic              found;
        logic [KIND_W-1:0] best_kind;
        logic [OBJ_W-1:0]  best_object;
        logic [DIST_W-1:0] best_distance;
        logic [WORD_W-1:0] best_x;
        logic [WORD_W-1:0] best_y;
        logic [WORD_W-1:0] best_z;
    } result_t;

    typedef struct packed {
        logic [MASK_W-1:0] allowed_kinds;
        logic [DIST_W-1:0] max_distance;
    } cfg_t;

    // A classified candidate as it waits between front and back.
    typedef struct packed {
        logic              pass;
        logic              last;
        logic [KIND_W-1:0] kind;
        logic [OBJ_W-1:0]  object;
        logic [DIST_W-1:0] distance;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qhead_t;

    function automatic logic word_finite(input logic [WORD_W-1:0] w);
        return w[EXP_LSB +: EXP_W] != EXP_SPECIAL;
    endfunction

endpackage

// ===== rtl/snc_if.sv =====
// ----------------------------------------------------------------------------
// Snap candidate selector stream interfaces
// Valid/ready channels for candidate items and result items.
// ----------------------------------------------------------------------------
interface snc_cand_if
    import snc_pkg::*;
();
    logic  valid;
    logic  ready;
    cand_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface snc_res_if
    import snc_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/snap_candidate_selector.sv =====
// ----------------------------------------------------------------------------
// Snap candidate selector
// Streams snap candidates and reports the best one at the end of each list.
// ----------------------------------------------------------------------------
// Candidates arrive one item per cycle on the cand channel while cand.ready
// is high; results leave on the res channel, one for each last candidate.
// A last candidate is stored in the queue before its result is registered.
// Throughput is one candidate per cycle while res is not stalled, set by the
// single compare-and-update step of the back end, one queued item each cycle.
// A two-entry queue lies between classification and selection. When res is
// stalled, the result register holds its item and candidates that are not
// last keep flowing; the next last candidate waits at the queue head, and
// cand.ready falls once the queue is full.
// Reset empties the queue and the held best and sets allowed_kinds to all
// kinds and max_distance to its largest value. The APB port writes the two
// registers at byte addresses 0 and 4 and reads them back; it is meant to be
// written only while no list is in flight.
// ----------------------------------------------------------------------------
module snap_candidate_selector
    import snc_pkg::*;
#(
    parameter int DISTANCE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    snc_cand_if.sink              cand,
    snc_res_if.source             res
);

    localparam int DW = (DISTANCE_BITS < DIST_W) ? DISTANCE_BITS : DIST_W;
    localparam logic [DIST_W-1:0] DIST_MASK = DIST_W'((33'd1 << DW) - 33'd1);

    logic [MASK_W-1:0] allowed_reg;
    logic [MASK_W-1:0] allowed_next;
    logic [DIST_W-1:0] max_dist_reg;
    logic [DIST_W-1:0] max_dist_next;
    logic              wr_en;
    cfg_t              cfg;
    logic              q_full;
    logic              push;
    logic              pop;
    qentry_t           entry;
    qhead_t            head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        allowed_next  = allowed_reg;
        max_dist_next = max_dist_reg;
        if (wr_en)
        begin
            case (paddr)
                ADDR_ALLOWED_KINDS: allowed_next  = pwdata[MASK_W-1:0];
                ADDR_MAX_DISTANCE:  max_dist_next = pwdata[DIST_W-1:0] & DIST_MASK;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_ALLOWED_KINDS: prdata = {{(APB_DATA_W-MASK_W){1'b0}}, allowed_reg};
            ADDR_MAX_DISTANCE:  prdata = {{(APB_DATA_W-DIST_W){1'b0}}, max_dist_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allowed_reg  <= ALLOWED_KINDS_RESET;
            max_dist_reg <= MAX_DISTANCE_RESET & DIST_MASK;
        end
        else
        begin
            allowed_reg  <= allowed_next;
            max_dist_reg <= max_dist_next;
        end
    end

    assign cfg.allowed_kinds = allowed_reg;
    assign cfg.max_distance  = max_dist_reg;

    snc_front #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_front (
        .in_valid (cand.valid),
        .cand     (cand.payload),
        .cfg      (cfg),
        .q_full   (q_full),
        .in_ready (cand.ready),
        .push     (push),
        .entry    (entry)
    );

    snc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .full       (q_full),
        .head       (head)
    );

    snc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_item  (res.payload)
    );

endmodule

// ===== rtl/snc_front.sv =====
// ----------------------------------------------------------------------------
// Snap candidate selector front
// Accepts candidate items while the queue has room and classifies them.
// ----------------------------------------------------------------------------
module snc_front
    import snc_pkg::*;
#(
    parameter int DISTANCE_BITS = 16
)
(
    input  logic    in_valid,
    input  cand_t   cand,
    input  cfg_t    cfg,
    input  logic    q_full,
    output logic    in_ready,
    output logic    push,
    output qentry_t entry
);

    localparam int DW = (DISTANCE_BITS < DIST_W) ? DISTANCE_BITS : DIST_W;
    localparam logic [DIST_W-1:0] DIST_MASK = DIST_W'((33'd1 << DW) - 33'd1);

    logic [DIST_W-1:0] dist_masked;
    logic [7:0]        allowed_ext;
    logic              kind_ok;
    logic              dist_ok;
    logic              pos_ok;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign dist_masked = cand.screen_distance & DIST_MASK;
    // Widened so that the none code and the unused code index a zero bit.
    assign allowed_ext = {2'b00, cfg.allowed_kinds};
    assign kind_ok     = (cand.snap_kind < KIND_NONE) && allowed_ext[cand.snap_kind];
    assign dist_ok     = cand.distance_is_finite && (dist_masked <= cfg.max_distance);
    assign pos_ok      = word_finite(cand.position_x) && word_finite(cand.position_y)
                         && word_finite(cand.position_z);

    always_comb
    begin
        entry.pass     = kind_ok && dist_ok && pos_ok;
        entry.last     = cand.last_in_list;
        entry.kind     = cand.snap_kind;
        entry.object   = cand.object_id;
        entry.distance = dist_masked;
        entry.pos_x    = cand.position_x;
        entry.pos_y    = cand.position_y;
        entry.pos_z    = cand.position_z;
    end

endmodule

// ===== rtl/snc_queue.sv =====
// ----------------------------------------------------------------------------
// Snap candidate selector queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module snc_queue
    import snc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qentry_t push_entry,
    input  logic    pop,
    output logic    full,
    output qhead_t  head
);

    qentry_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full       = (count_reg == QCOUNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/snc_back.sv =====
// ----------------------------------------------------------------------------
// Snap candidate selector back
// Keeps the running best and loads the result register on the last item.
// ----------------------------------------------------------------------------
module snc_back
    import snc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  qhead_t  head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    logic              have_reg;
    logic              have_next;
    logic [KIND_W-1:0] kind_reg;
    logic [OBJ_W-1:0]  obj_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] z_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           out_next;
    logic              out_free;
    logic              better;
    logic              take;
    logic              have_upd;
    logic              emit;

    assign out_free = !out_valid_reg || out_ready;
    // A last item may leave the queue only when the result register is free.
    assign pop      = head.valid && (!head.entry.last || out_free);
    assign emit     = pop && head.entry.last;

    assign better = !have_reg
                    || (head.entry.kind < kind_reg)
                    || ((head.entry.kind == kind_reg)
                        && ((head.entry.distance < dist_reg)
                            || ((head.entry.distance == dist_reg)
                                && (head.entry.object < obj_reg))));
    assign take     = pop && head.entry.pass && better;
    assign have_upd = have_reg || take;

    always_comb
    begin
        have_next      = emit ? 1'b0 : have_upd;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (!have_upd)
            begin
                out_next = '0;
            end
            else if (take)
            begin
                out_next.found         = 1'b1;
                out_next.best_kind     = head.entry.kind;
                out_next.best_object   = head.entry.object;
                out_next.best_distance = head.entry.distance;
                out_next.best_x        = head.entry.pos_x;
                out_next.best_y        = head.entry.pos_y;
                out_next.best_z        = head.entry.pos_z;
            end
            else
            begin
                out_next.found         = 1'b1;
                out_next.best_kind     = kind_reg;
                out_next.best_object   = obj_reg;
                out_next.best_distance = dist_reg;
                out_next.best_x        = x_reg;
                out_next.best_y        = y_reg;
                out_next.best_z        = z_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= head.entry.kind;
            obj_reg  <= head.entry.object;
            dist_reg <= head.entry.distance;
            x_reg    <= head.entry.pos_x;
            y_reg    <= head.entry.pos_y;
            z_reg    <= head.entry.pos_z;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/snc_checker.sv =====
// ----------------------------------------------------------------------------
// Snap candidate selector checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "snap_candidate_selector_macros.svh"

module snc_checker
    import snc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_payload
);

    // A stalled result stays offered and unchanged.
    `SNC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload))

    // An empty result carries nothing but zeros.
    `SNC_ASSERT_SAME(a_empty_zero, res_valid && !res_payload.found, res_payload == '0)

    // A found candidate never has the none kind or the unused code.
    `SNC_ASSERT_SAME(a_found_kind, res_valid && res_payload.found, res_payload.best_kind < KIND_NONE)

endmodule

bind snap_candidate_selector snc_checker u_snc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Snap candidate selector testbench
// Drives lists of snap candidates through the selector under several register
// settings, with random gaps on both channels and one long result stall, and
// checks every result item against a running best-candidate predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import snc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_VERTEX     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE_MID   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FACE       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BOX_CORNER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BOX_CENTRE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FLOOR      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_INVALID    = 3'd7;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;

    // Tracks the best candidate of the current list and the results owed.
    class snap_pick_board;
        logic [MASK_W-1:0] kind_mask;
        logic [DIST_W-1:0] distance_limit;
        logic              holding;
        logic [KIND_W-1:0] hold_kind;
        logic [OBJ_W-1:0]  hold_object;
        logic [DIST_W-1:0] hold_distance;
        logic [WORD_W-1:0] hold_x;
        logic [WORD_W-1:0] hold_y;
        logic [WORD_W-1:0] hold_z;
        result_t           awaited_picks[$];
        int                mismatches;

        function new();
            kind_mask      = ALLOWED_KINDS_RESET;
            distance_limit = MAX_DISTANCE_RESET;
            mismatches     = 0;
            clear_hold();
        endfunction

        function void clear_hold();
            holding       = 1'b0;
            hold_kind     = '0;
            hold_object   = '0;
            hold_distance = '0;
            hold_x        = '0;
            hold_y        = '0;
            hold_z        = '0;
        endfunction

        function logic is_real_number(logic [WORD_W-1:0] w);
            return w[30:23] != 8'hFF;
        endfunction

        function void note_candidate(cand_t c);
            logic [7:0] enabled;
            logic       accept;
            logic       take;
            result_t    pick;
            enabled = {2'b00, kind_mask};
            accept  = (c.snap_kind < KIND_NONE) && enabled[c.snap_kind] &&
                      c.distance_is_finite && (c.screen_distance <= distance_limit) &&
                      is_real_number(c.position_x) && is_real_number(c.position_y) &&
                      is_real_number(c.position_z);
            take = !holding || (c.snap_kind < hold_kind) ||
                   (c.snap_kind == hold_kind &&
                    (c.screen_distance < hold_distance ||
                     (c.screen_distance == hold_distance && c.object_id < hold_object)));
            if (accept && take)
            begin
                holding       = 1'b1;
                hold_kind     = c.snap_kind;
                hold_object   = c.object_id;
                hold_distance = c.screen_distance;
                hold_x        = c.position_x;
                hold_y        = c.position_y;
                hold_z        = c.position_z;
            end
            if (c.last_in_list)
            begin
                // With nothing held every field is zero, found included.
                pick.found         = holding;
                pick.best_kind     = hold_kind;
                pick.best_object   = hold_object;
                pick.best_distance = hold_distance;
                pick.best_x        = hold_x;
                pick.best_y        = hold_y;
                pick.best_z        = hold_z;
                awaited_picks = {awaited_picks, pick};
                clear_hold();
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t r);
            result_t want;
            if (awaited_picks.size() == 0)
            begin
                $error("result item with none expected: found 0x%0h, best_object 0x%0h",
                       r.found, r.best_object);
                mismatches++;
                return;
            end
            want = awaited_picks.pop_front();
            compare_field("found", want.found, r.found);
            compare_field("best_kind", want.best_kind, r.best_kind);
            compare_field("best_object", want.best_object, r.best_object);
            compare_field("best_distance", want.best_distance, r.best_distance);
            compare_field("best_x", want.best_x, r.best_x);
            compare_field("best_y", want.best_y, r.best_y);
            compare_field("best_z", want.best_z, r.best_z);
        endfunction

        function int pending();
            return awaited_picks.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    snc_cand_if cand_ch();
    snc_res_if  res_ch();

    snap_pick_board board;
    bit             src_gaps;
    bit             sink_gaps;
    bit             hold_request;
    int             cycle_count = 0;

    snap_candidate_selector i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cand    (cand_ch),
        .res     (res_ch)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] finite_word();
        logic [WORD_W-1:0] w;
        w = $urandom;
        if (w[30:23] == 8'hFF)
            w[23 + $urandom_range(0, 7)] = 1'b0;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] position_word();
        logic [WORD_W-1:0] w;
        w = finite_word();
        if ($urandom_range(0, 29) == 0)
            w[30:23] = 8'hFF;
        return w;
    endfunction

    function automatic cand_t build_candidate(logic [KIND_W-1:0] kind, logic [OBJ_W-1:0] obj,
                                              logic [DIST_W-1:0] dist_val, logic dist_ok,
                                              logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                                              logic [WORD_W-1:0] z, logic last);
        cand_t c;
        c.snap_kind          = kind;
        c.object_id          = obj;
        c.screen_distance    = dist_val;
        c.distance_is_finite = dist_ok;
        c.position_x         = x;
        c.position_y         = y;
        c.position_z         = z;
        c.last_in_list       = last;
        return c;
    endfunction

    // Small pools for object and distance make ties frequent.
    function automatic cand_t random_candidate(logic last, logic [DIST_W-1:0] limit);
        cand_t c;
        if ($urandom_range(0, 15) == 0)
            c.snap_kind = $urandom_range(0, 1) ? KIND_NONE : KIND_INVALID;
        else
            c.snap_kind = KIND_W'($urandom_range(0, KIND_FLOOR));
        c.object_id = $urandom_range(0, 1) ? OBJ_W'($urandom_range(0, 3)) : OBJ_W'($urandom);
        case ($urandom_range(0, 7))
            0:       c.screen_distance = limit;
            1:       c.screen_distance = limit + 1'b1;
            2:       c.screen_distance = DIST_W'($urandom);
            3:       c.screen_distance = DIST_W'($urandom_range(0, 3));
            default: c.screen_distance = DIST_W'($urandom_range(0, limit));
        endcase
        c.distance_is_finite = $urandom_range(0, 19) != 0;
        c.position_x         = position_word();
        c.position_y         = position_word();
        c.position_z         = position_word();
        c.last_in_list       = last;
        return c;
    endfunction

    task automatic send_candidate(input cand_t c);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            cand_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cand_ch.valid   <= 1'b1;
        cand_ch.payload <= c;
        @(posedge clk);
        while (!cand_ch.ready) @(posedge clk);
        board.note_candidate(c);
    endtask

    task automatic drain();
        cand_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ALLOWED_KINDS)
            board.kind_mask = value[MASK_W-1:0];
        else
            board.distance_limit = value[DIST_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_config(input logic [MASK_W-1:0] mask, input logic [DIST_W-1:0] limit);
        drain();
        write_reg(ADDR_ALLOWED_KINDS, 32'(mask));
        write_reg(ADDR_MAX_DISTANCE, 32'(limit));
    endtask

    task automatic run_lists(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                send_candidate(random_candidate(k == len - 1, board.distance_limit));
            sent += len;
        end
    endtask

    initial
    begin : result_side
        int n;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
                res_ch.ready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 17);
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : result_watch
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                board.check_result(res_ch.payload);
        end
    end

    initial
    begin : stimulus
        board           = new();
        src_gaps        = 1'b1;
        sink_gaps       = 1'b1;
        hold_request    = 1'b0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cand_ch.valid   <= 1'b0;
        cand_ch.payload <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, none and invalid kinds, finite distance and position rejection on its own, one-item lists.
        send_candidate(build_candidate(KIND_VERTEX, '0, '0, 1'b1, '0, '0, '0, 1'b1));
        send_candidate(build_candidate(KIND_FLOOR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                       32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h8000_0000, 1'b1));
        send_candidate(build_candidate(KIND_NONE, 1, 1, 1'b1, '0, '0, '0, 1'b1));
        send_candidate(build_candidate(KIND_INVALID, 1, 1, 1'b1, '0, '0, '0, 1'b1));
        send_candidate(build_candidate(KIND_EDGE_MID, 2, 3, 1'b0, '0, '0, '0, 1'b1));
        send_candidate(build_candidate(KIND_EDGE_MID, 2, 3, 1'b1, 32'h7F80_0000, '0, '0, 1'b1));
        send_candidate(build_candidate(KIND_EDGE_MID, 2, 3, 1'b1, '0, 32'h7FC0_0001, '0, 1'b1));
        send_candidate(build_candidate(KIND_EDGE_MID, 2, 3, 1'b1, '0, '0, 32'hFF80_0000, 1'b1));

        // Ordering: an exact tie keeps the held best, then object, distance, kind.
        send_candidate(build_candidate(KIND_BOX_CORNER, 9, 5, 1'b1, 1, 2, 3, 1'b0));
        send_candidate(build_candidate(KIND_BOX_CORNER, 9, 5, 1'b1, 4, 5, 6, 1'b0));
        send_candidate(build_candidate(KIND_BOX_CENTRE, 1, 1, 1'b1, 7, 8, 9, 1'b0));
        send_candidate(build_candidate(KIND_BOX_CORNER, 12, 5, 1'b1, 10, 11, 12, 1'b0));
        send_candidate(build_candidate(KIND_BOX_CORNER, 2, 5, 1'b1, 13, 14, 15, 1'b0));
        send_candidate(build_candidate(KIND_BOX_CORNER, 3, 4, 1'b1, 16, 17, 18, 1'b0));
        send_candidate(build_candidate(KIND_EDGE_MID, 50, 100, 1'b1, 19, 20, 21, 1'b1));
        send_candidate(build_candidate(KIND_FACE, 7, 8, 1'b1, 32'h7F80_0000, 0, 0, 1'b0));
        send_candidate(build_candidate(KIND_FLOOR, 8, 9, 1'b1, 22, 23, 24, 1'b1));

        // An empty mask finds nothing.
        set_config('0, MAX_DISTANCE_RESET);
        send_candidate(build_candidate(KIND_VERTEX, 0, 0, 1'b1, 0, 0, 0, 1'b1));

        // Face centres only, at zero distance only.
        set_config(MASK_W'(1 << KIND_FACE), '0);
        send_candidate(build_candidate(KIND_VERTEX, 1, 0, 1'b1, 25, 26, 27, 1'b0));
        send_candidate(build_candidate(KIND_FACE, 4, 1, 1'b1, 28, 29, 30, 1'b0));
        send_candidate(build_candidate(KIND_FACE, 5, 0, 1'b1, 31, 32, 33, 1'b1));

        set_config(ALLOWED_KINDS_RESET, MAX_DISTANCE_RESET);
        run_lists(250);

        set_config('0, DIST_W'($urandom));
        run_lists(50);

        set_config(MASK_W'($urandom_range(1, 62)), '0);
        run_lists(50);

        // Results are held off for a long stretch while candidates keep coming.
        set_config(MASK_W'($urandom_range(1, 62)), DIST_W'($urandom));
        hold_request = 1'b1;
        run_lists(250);

        set_config(MASK_W'(1 << $urandom_range(0, 5)), DIST_W'($urandom));
        run_lists(200);

        set_config(ALLOWED_KINDS_RESET, MAX_DISTANCE_RESET);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_lists(250);

        drain();
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== snap_candidate_selector.f =====
+incdir+rtl
rtl/snc_pkg.sv
rtl/snc_if.sv
rtl/snc_front.sv
rtl/snc_queue.sv
rtl/snc_back.sv
rtl/snap_candidate_selector.sv
rtl/snc_checker.sv
sim/tb_top.sv
